FILE: hw/rtl/tgad_pkg.sv
// Shared types and constants for the TGA run-length pixel decoder.
package tgad_pkg;

    // Packet header fields
    localparam logic [7:0] HDR_COUNT_MASK = 8'h7f;
    localparam logic [7:0] HDR_RUN_BIT    = 8'h80;

    // Configuration register indexes
    localparam logic [1:0] CFG_BYTES_PER_PIXEL = 2'd0;
    localparam logic [1:0] CFG_RLE_ENABLED     = 2'd1;
    localparam logic [1:0] CFG_TOTAL_PIXELS    = 2'd2;

    localparam int CFG_INDEX_W = 2;

    // Classified stream byte, as it sits in the queue
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_image;
        logic       hdr_run;
        logic [7:0] hdr_count;
    } queue_item_t;

    // One configuration write
    typedef struct packed {
        logic                   valid;
        logic [CFG_INDEX_W-1:0] index;
        logic [31:0]            data;
    } cfg_write_t;

endpackage

FILE: hw/rtl/tgad_front.sv
// Front end: accepts stream bytes and pre-decodes the packet header fields.
module tgad_front (
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           data_byte,
    input  logic                 start_image,
    output logic                 push_valid,
    input  logic                 push_ready,
    output tgad_pkg::queue_item_t push_item
);
    import tgad_pkg::*;

    // Accept whenever the queue has room
    assign in_ready   = push_ready;
    assign push_valid = in_valid;

    // Split out the header fields so the back end only selects
    always_comb
    begin
        push_item.data_byte   = data_byte;
        push_item.start_image = start_image;
        push_item.hdr_run     = (data_byte & HDR_RUN_BIT) != 8'h00;
        push_item.hdr_count   = (data_byte & HDR_COUNT_MASK) + 8'd1;
    end

endmodule

FILE: hw/rtl/tgad_queue.sv
// Small FIFO between the front end and the decode back end.
module tgad_queue #(
    parameter int DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  tgad_pkg::queue_item_t push_item,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output tgad_pkg::queue_item_t pop_item,
    output logic [$clog2(DEPTH+1)-1:0] level
);
    import tgad_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    queue_item_t       mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = count_reg != FULL_CNT;
    assign pop_valid  = count_reg != '0;
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign level      = count_reg;

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the item
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: hw/rtl/tgad_back.sv
// Back end: packet state, pixel assembly, pixel counting and result register.
module tgad_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tgad_pkg::cfg_write_t  cfg_wr,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  tgad_pkg::queue_item_t pop_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [31:0]           pixel_value,
    output logic [7:0]            repeat_count,
    output logic                  image_done
);
    import tgad_pkg::*;

    // Configuration
    logic [2:0]  bpp_reg;
    logic        rle_reg;
    logic [31:0] total_reg;

    // Decode state
    logic        expect_header_reg, expect_header_next;
    logic        run_packet_reg, run_packet_next;
    logic [7:0]  pkt_left_reg, pkt_left_next;
    logic [1:0]  byte_pos_reg, byte_pos_next;
    logic [31:0] pixel_asm_reg, pixel_asm_next;
    logic [31:0] emitted_reg, emitted_next;

    // Result register
    logic        out_valid_reg, out_valid_next;
    logic [31:0] pixel_value_reg;
    logic [7:0]  repeat_count_reg;
    logic        image_done_reg;

    // Working values
    logic        fire;
    logic        emit;
    logic        cur_eh, cur_rp;
    logic [7:0]  cur_pl;
    logic [1:0]  cur_bp;
    logic [31:0] cur_pa, cur_pe;
    logic [32:0] remaining;
    logic        done;
    logic [2:0]  size;
    logic [2:0]  pos_inc;
    logic [31:0] pa_merged;
    logic [7:0]  rep_base, rep;
    logic        rep_done;

    assign fire      = pop_valid && (!out_valid_reg || out_ready);
    assign pop_ready = !out_valid_reg || out_ready;

    // Apply configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg   <= 3'd3;
            rle_reg   <= 1'b1;
            total_reg <= 32'd1;
        end
        else if (cfg_wr.valid)
        begin
            case (cfg_wr.index)
                CFG_BYTES_PER_PIXEL: bpp_reg   <= cfg_wr.data[2:0];
                CFG_RLE_ENABLED:     rle_reg   <= cfg_wr.data[0];
                CFG_TOTAL_PIXELS:    total_reg <= cfg_wr.data;
                default:             ;
            endcase
        end
    end

    // Start of image drops the decode state before the byte is used
    always_comb
    begin
        if (pop_item.start_image)
        begin
            cur_eh = 1'b1;
            cur_rp = 1'b0;
            cur_pl = '0;
            cur_bp = '0;
            cur_pa = '0;
            cur_pe = '0;
        end
        else
        begin
            cur_eh = expect_header_reg;
            cur_rp = run_packet_reg;
            cur_pl = pkt_left_reg;
            cur_bp = byte_pos_reg;
            cur_pa = pixel_asm_reg;
            cur_pe = emitted_reg;
        end
    end

    // Pixels still missing; none left or a borrow means the image is complete
    assign remaining = {1'b0, total_reg} - {1'b0, cur_pe};
    assign done      = remaining[32] || (remaining[31:0] == 32'h0);

    // Clamp the pixel size to 1..4
    always_comb
    begin
        case (bpp_reg)
            3'd0:    size = 3'd1;
            3'd1:    size = 3'd1;
            3'd2:    size = 3'd2;
            3'd3:    size = 3'd3;
            3'd4:    size = 3'd4;
            default: size = 3'd4;
        endcase
    end

    assign pos_inc   = {1'b0, cur_bp} + 3'd1;
    assign pa_merged = cur_pa | ({24'h0, pop_item.data_byte} << {cur_bp, 3'b000});

    // Repeat count, clipped to the missing pixels
    always_comb
    begin
        if (rle_reg && cur_rp)
        begin
            rep_base = (cur_pl == 8'd0) ? 8'd1 : cur_pl;
        end
        else
        begin
            rep_base = 8'd1;
        end
        if ((remaining[31:8] == 24'h0) && (rep_base > remaining[7:0]))
        begin
            rep = remaining[7:0];
        end
        else
        begin
            rep = rep_base;
        end
    end

    assign rep_done = remaining[31:0] == {24'h0, rep};

    // Decode one byte
    always_comb
    begin
        expect_header_next = cur_eh;
        run_packet_next    = cur_rp;
        pkt_left_next      = cur_pl;
        byte_pos_next      = cur_bp;
        pixel_asm_next     = cur_pa;
        emitted_next       = cur_pe;
        emit               = 1'b0;
        if (!done)
        begin
            if (rle_reg && cur_eh)
            begin
                run_packet_next    = pop_item.hdr_run;
                pkt_left_next      = pop_item.hdr_count;
                expect_header_next = 1'b0;
                byte_pos_next      = '0;
                pixel_asm_next     = '0;
            end
            else if (pos_inc < size)
            begin
                byte_pos_next  = pos_inc[1:0];
                pixel_asm_next = pa_merged;
            end
            else
            begin
                emit           = 1'b1;
                byte_pos_next  = '0;
                pixel_asm_next = '0;
                emitted_next   = cur_pe + {24'h0, rep};
                if (rle_reg)
                begin
                    if (cur_rp || (cur_pl <= 8'd1))
                    begin
                        pkt_left_next      = '0;
                        expect_header_next = 1'b1;
                    end
                    else
                    begin
                        pkt_left_next = cur_pl - 8'd1;
                    end
                end
            end
        end
    end

    // Hold the result until taken
    always_comb
    begin
        if (fire && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_header_reg <= 1'b1;
            run_packet_reg    <= 1'b0;
            pkt_left_reg      <= '0;
            byte_pos_reg      <= '0;
            pixel_asm_reg     <= '0;
            emitted_reg       <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                expect_header_reg <= expect_header_next;
                run_packet_reg    <= run_packet_next;
                pkt_left_reg      <= pkt_left_next;
                byte_pos_reg      <= byte_pos_next;
                pixel_asm_reg     <= pixel_asm_next;
                emitted_reg       <= emitted_next;
            end
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            pixel_value_reg  <= pa_merged;
            repeat_count_reg <= rep;
            image_done_reg   <= rep_done;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_value  = pixel_value_reg;
    assign repeat_count = repeat_count_reg;
    assign image_done   = image_done_reg;

endmodule

FILE: hw/rtl/tga_rle_pixel_decoder.sv
// A pixel's last byte goes through the queue; its item then loads the result register.
// One byte per cycle while the queue has room; the back end retires one per cycle unless held.
// Header bytes and bytes after image completion are consumed and give no item.
// The output register frees in the cycle its item is taken, so results can stream one per cycle.
// Reset (rst_n low, asynchronous): queue emptied, awaiting a packet header, counts cleared,
// registers at 3 bytes per pixel, run-length coding on, total of one pixel.
module tga_rle_pixel_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        start_image,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] pixel_value,
    output logic [7:0]  repeat_count,
    output logic        image_done
);
    import tgad_pkg::*;

    localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1);

    logic                push_valid, push_ready;
    queue_item_t         push_item;
    logic                pop_valid, pop_ready;
    queue_item_t         pop_item;
    logic [LEVEL_W-1:0]  q_level;
    cfg_write_t          cfg_wr;

    // Configuration writes are taken at once
    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    tgad_front u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .start_image (start_image),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_item   (push_item)
    );

    tgad_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .level      (q_level)
    );

    tgad_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr       (cfg_wr),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_item     (pop_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_value  (pixel_value),
        .repeat_count (repeat_count),
        .image_done   (image_done)
    );

    // Bytes are only taken while the queue has room
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> (q_level < LEVEL_W'(QUEUE_DEPTH)))
        else $error("byte accepted into a full queue");

    // A delivered pixel item always covers at least one and at most 128 pixels
    a_rep_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((repeat_count != 8'd0) && (repeat_count <= 8'd128)))
        else $error("repeat count out of range");

    // Queue occupancy and its valid flag agree
    a_queue_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop_valid == (q_level != '0))
        else $error("queue valid disagrees with level");

endmodule

FILE: dv/tga_rle_pixel_decoder_tb.sv
// Testbench for the TGA run-length pixel decoder: directed rows, then random images.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tgad_pkg::*;

    localparam int CYCLE_LIMIT   = 250000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int SEGMENT_ITEMS = 520;

    typedef struct packed {
        logic [31:0] pixel;
        logic [7:0]  reps;
        logic        done;
    } pixel_res_t;

    typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_e;

    typedef struct packed {
        row_kind_e   kind;
        logic [1:0]  index;
        logic [31:0] value;     // register data, or the stream byte in bits 7:0
        logic        start;
        logic        fixed;     // result typed in below instead of predicted
        pixel_res_t  res;
    } stim_row_t;

    localparam pixel_res_t NO_RES = '0;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        start_image;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] pixel_value;
    logic [7:0]  repeat_count;
    logic        image_done;

    // Typed-in expectation that travels with the byte on the input channel
    logic        in_fixed;
    pixel_res_t  in_fixed_res;

    // Decoder copy: registers and decoding state
    logic [2:0]  pred_bpp;
    logic        pred_rle;
    logic [31:0] pred_total;
    logic        pred_hdr_wait;
    logic        pred_run;
    logic [7:0]  pred_pkt_left;
    logic [1:0]  pred_pos;
    logic [31:0] pred_acc;
    logic [31:0] pred_emitted;

    pixel_res_t  pending_pixels [$];

    int errors        = 0;
    int items_in      = 0;
    int results_seen  = 0;
    int images_done   = 0;
    int cfg_writes    = 0;
    int hold_asked    = 0;
    int hold_served   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count   = 0;

    stim_row_t directed_rows [$] = '{
        // one-pixel image at reset settings: run of one, three bytes, then a stray byte
        '{ROW_BYTE, '0, 32'h80, 1'b1, 1'b0, NO_RES},
        '{ROW_BYTE, '0, 32'h11, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, '0, 32'h22, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, '0, 32'h33, 1'b0, 1'b1, '{32'h0033_2211, 8'd1, 1'b1}},
        '{ROW_BYTE, '0, 32'hff, 1'b0, 1'b0, NO_RES},
        // zero total: ignored even on restart
        '{ROW_CFG, CFG_TOTAL_PIXELS, 32'd0, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, '0, 32'h5a, 1'b1, 1'b0, NO_RES},
        // largest image, 4-byte pixels, longest run
        '{ROW_CFG, CFG_TOTAL_PIXELS, 32'hfffe_0001, 1'b0, 1'b0, NO_RES},
        '{ROW_CFG, CFG_BYTES_PER_PIXEL, 32'd4, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, '0, 32'hff, 1'b1, 1'b0, NO_RES},
        '{ROW_BYTE, '0, 32'hff, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, '0, 32'hff, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, '0, 32'hff, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, '0, 32'hff, 1'b0, 1'b1, '{32'hffff_ffff, 8'd128, 1'b0}},
        // longest literal packet; pixel size 0 acts as one byte
        '{ROW_BYTE, '0, 32'h7f, 1'b0, 1'b0, NO_RES},
        '{ROW_CFG, CFG_BYTES_PER_PIXEL, 32'd0, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, '0, 32'h00, 1'b0, 1'b1, '{32'h0000_0000, 8'd1, 1'b0}},
        // size 7 acts as four; shrink to one byte with two bytes already in
        '{ROW_CFG, CFG_BYTES_PER_PIXEL, 32'd7, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, '0, 32'h12, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, '0, 32'h34, 1'b0, 1'b0, NO_RES},
        '{ROW_CFG, CFG_BYTES_PER_PIXEL, 32'hffff_fff9, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, '0, 32'h56, 1'b0, 1'b0, NO_RES},
        // raw mode mid-packet, then back into the same literal packet
        '{ROW_CFG, CFG_RLE_ENABLED, 32'd0, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, '0, 32'ha5, 1'b0, 1'b0, NO_RES},
        '{ROW_CFG, CFG_RLE_ENABLED, 32'hffff_ffff, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, '0, 32'h3c, 1'b0, 1'b0, NO_RES},
        // run of six clipped to a five-pixel image
        '{ROW_CFG, CFG_TOTAL_PIXELS, 32'd5, 1'b0, 1'b0, NO_RES},
        '{ROW_CFG, CFG_BYTES_PER_PIXEL, 32'd2, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, '0, 32'h85, 1'b1, 1'b0, NO_RES},
        '{ROW_BYTE, '0, 32'hef, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, '0, 32'hbe, 1'b0, 1'b1, '{32'h0000_beef, 8'd5, 1'b1}},
        '{ROW_BYTE, '0, 32'h00, 1'b0, 1'b0, NO_RES},
        // literal packet of four into a two-pixel image
        '{ROW_CFG, CFG_TOTAL_PIXELS, 32'd2, 1'b0, 1'b0, NO_RES},
        '{ROW_CFG, CFG_BYTES_PER_PIXEL, 32'd1, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, '0, 32'h03, 1'b1, 1'b0, NO_RES},
        '{ROW_BYTE, '0, 32'h01, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, '0, 32'h02, 1'b0, 1'b1, '{32'h0000_0002, 8'd1, 1'b1}},
        '{ROW_BYTE, '0, 32'h03, 1'b0, 1'b0, NO_RES}
    };

    tga_rle_pixel_decoder dut (.*);

    // Clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Drop all decoding state, keep the registers
    function automatic void clear_decoder();
        pred_hdr_wait = 1'b1;
        pred_run      = 1'b0;
        pred_pkt_left = '0;
        pred_pos      = '0;
        pred_acc      = '0;
        pred_emitted  = '0;
    endfunction

    // Advance the decoder copy by one byte; return 1 when a pixel item comes out
    function automatic logic decode_byte(input logic [7:0] b, input logic st,
                                         output pixel_res_t r);
        int          size;
        logic [31:0] remaining;
        logic [31:0] rep;
        r = '0;
        if (st)
            clear_decoder();
        if (pred_emitted >= pred_total)
            return 1'b0;

        // Packet header: latch kind and count, no item
        if (pred_rle && pred_hdr_wait)
        begin
            pred_run      = (b & HDR_RUN_BIT) != 0;
            pred_pkt_left = (b & HDR_COUNT_MASK) + 8'd1;
            pred_hdr_wait = 1'b0;
            pred_pos      = '0;
            pred_acc      = '0;
            return 1'b0;
        end

        // Assemble the pixel, low byte first
        size = (pred_bpp == 0) ? 1 : (pred_bpp > 4) ? 4 : int'(pred_bpp);
        pred_acc |= 32'(b) << (8 * pred_pos);
        if (int'(pred_pos) + 1 < size)
        begin
            pred_pos = pred_pos + 2'd1;
            return 1'b0;
        end

        // Pixel complete: work out the repeat and the packet progress
        remaining = pred_total - pred_emitted;
        rep = 32'd1;
        if (pred_rle)
        begin
            if (pred_run)
            begin
                rep = (pred_pkt_left == 0) ? 32'd1 : 32'(pred_pkt_left);
                if (rep > remaining)
                    rep = remaining;
                pred_pkt_left = '0;
                pred_hdr_wait = 1'b1;
            end
            else if (pred_pkt_left <= 1)
            begin
                pred_pkt_left = '0;
                pred_hdr_wait = 1'b1;
            end
            else
                pred_pkt_left = pred_pkt_left - 8'd1;
        end

        pred_emitted += rep;
        r.pixel = pred_acc;
        r.reps  = rep[7:0];
        r.done  = (pred_emitted == pred_total);
        pred_pos = '0;
        pred_acc = '0;
        return 1'b1;
    endfunction

    // Predict on every accepted byte
    always @(posedge clk)
    begin
        pixel_res_t r;
        if (rst_n && in_valid && in_ready)
        begin
            items_in++;
            if (decode_byte(data_byte, start_image, r))
                pending_pixels.push_back(in_fixed ? in_fixed_res : r);
        end
    end

    // Compare every accepted pixel item with the oldest prediction
    always @(posedge clk)
    begin
        pixel_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (image_done)
                images_done++;
            if (pending_pixels.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected item pixel_value %h repeat_count %0d image_done %0b",
                         $time, pixel_value, repeat_count, image_done);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (pixel_value !== want.pixel)
                begin
                    errors++;
                    $display("%0t: pixel_value expected %h actual %h",
                             $time, want.pixel, pixel_value);
                end
                if (repeat_count !== want.reps)
                begin
                    errors++;
                    $display("%0t: repeat_count expected %0d actual %0d",
                             $time, want.reps, repeat_count);
                end
                if (image_done !== want.done)
                begin
                    errors++;
                    $display("%0t: image_done expected %0b actual %0b",
                             $time, want.done, image_done);
                end
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when asked
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asked != hold_served)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_served++;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d items still expected",
                     cycle_count, pending_pixels.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offer one byte, idling at random first, and hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic st, input logic fixed,
                             input pixel_res_t res);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        data_byte    <= b;
        start_image  <= st;
        in_fixed     <= fixed;
        in_fixed_res <= res;
        do @(posedge clk); while (!in_ready);
    endtask

    // Wait until every predicted item is out and the back end has gone quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one register on an idle block and mirror it in the decoder copy
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_BYTES_PER_PIXEL: pred_bpp   = val[2:0];
            CFG_RLE_ENABLED:     pred_rle   = val[0];
            CFG_TOTAL_PIXELS:    pred_total = val;
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Send one image of well-formed packets (or raw pixels) with random content
    task automatic send_image(input logic restart, input int goal);
        int   size;
        int   covered;
        int   count;
        logic run;
        logic st;
        size = (pred_bpp == 0) ? 1 : (pred_bpp > 4) ? 4 : int'(pred_bpp);
        st = restart;
        covered = 0;
        while (covered < goal)
        begin
            if (pred_rle)
            begin
                run = $urandom_range(0, 1);
                count = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 128)
                                                     : $urandom_range(1, 8);
                send_byte((run ? HDR_RUN_BIT : 8'h00) | (8'(count - 1) & HDR_COUNT_MASK),
                          st, 1'b0, NO_RES);
                st = 1'b0;
                repeat ((run ? 1 : count) * size)
                    send_byte(8'($urandom), 1'b0, 1'b0, NO_RES);
                covered += count;
            end
            else
            begin
                repeat (size)
                begin
                    send_byte(8'($urandom), st, 1'b0, NO_RES);
                    st = 1'b0;
                end
                covered++;
            end
        end
    endtask

    // Main sequence
    initial
    begin
        int          seg_base;
        int          pick;
        int          goal;
        logic [31:0] v;

        rst_n        <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        data_byte    <= '0;
        start_image  <= 1'b0;
        in_fixed     <= 1'b0;
        in_fixed_res <= NO_RES;
        pred_bpp   = 3'd3;
        pred_rle   = 1'b1;
        pred_total = 32'd1;
        clear_decoder();
        send_idle_pct = 31;
        recv_idle_pct = 63;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
                write_reg(directed_rows[i].index, directed_rows[i].value);
            else
                send_byte(directed_rows[i].value[7:0], directed_rows[i].start,
                          directed_rows[i].fixed, directed_rows[i].res);
        end

        // Random images under three idle patterns
        for (int seg = 0; seg < 3; seg++)
        begin
            send_idle_pct = (seg == 0) ? 31 : (seg == 1) ? 63 : 0;
            recv_idle_pct = (seg == 0) ? 63 : (seg == 1) ? 31 : 0;
            seg_base = items_in;

            // Hold the output while raw one-byte pixels keep coming, to back up the input
            write_reg(CFG_RLE_ENABLED, 32'd0);
            write_reg(CFG_BYTES_PER_PIXEL, 32'd1);
            write_reg(CFG_TOTAL_PIXELS, 32'd1000);
            hold_asked++;
            for (int k = 0; k < 40; k++)
                send_byte(8'($urandom), k == 0, 1'b0, NO_RES);

            while (items_in - seg_base < SEGMENT_ITEMS)
            begin
                if ($urandom_range(0, 1))
                begin
                    v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                                     : $urandom_range(1, 4);
                    write_reg(CFG_BYTES_PER_PIXEL, ($urandom & ~32'h7) | v);
                end
                if ($urandom_range(0, 3) == 0)
                    write_reg(CFG_RLE_ENABLED,
                              ($urandom & ~32'h1) | 32'($urandom_range(0, 4) != 0));
                if ($urandom_range(0, 1))
                begin
                    pick = $urandom_range(0, 19);
                    v = (pick == 0) ? 32'd0 :
                        (pick == 1) ? 32'hfffe_0001 :
                        (pick == 2) ? $urandom_range(32'hfffe_0001, 1) :
                                      $urandom_range(1, 40);
                    write_reg(CFG_TOTAL_PIXELS, v);
                end

                goal = (pred_total == 0) ? 3 : (pred_total > 48) ? 48 : int'(pred_total);
                pick = $urandom_range(0, 9);
                if (pick == 0)
                begin
                    // noise with the odd restart
                    repeat ($urandom_range(1, 12))
                        send_byte(8'($urandom), $urandom_range(0, 9) == 0, 1'b0, NO_RES);
                end
                else if (pick == 1)
                    send_image($urandom_range(0, 9) != 0, $urandom_range(1, goal));
                else
                begin
                    send_image($urandom_range(0, 9) != 0, goal);
                    if ($urandom_range(0, 3) == 0)
                        repeat ($urandom_range(1, 3))
                            send_byte(8'($urandom), 1'b0, 1'b0, NO_RES);
                end
            end
        end

        settle();

        $display("Decoded %0d stream bytes into %0d pixel items over %0d completed images.",
                 items_in, results_seen, images_done);
        $display("Used %0d register writes, three idle patterns and %0d output hold-offs.",
                 cfg_writes, hold_served);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/tgad_pkg.sv
hw/rtl/tgad_front.sv
hw/rtl/tgad_queue.sv
hw/rtl/tgad_back.sv
hw/rtl/tga_rle_pixel_decoder.sv
dv/tga_rle_pixel_decoder_tb.sv
